[rtl/assert_macros.svh]
// Assertion helpers. The asserting module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define PTACB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define PTACB_ASSERT_IMP(lbl, ante, cons, msg) \
  `PTACB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/ptacb_pkg.sv]
`timescale 1ns / 1ps
package ptacb_pkg;

  localparam int CMD_W  = 3;
  localparam int SMP_W  = 16;
  localparam int RIDX_W = 16;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 13;
  localparam int CNT_W  = 17;
  localparam int FS_W   = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DRAIN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FINAL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_ROLL_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT = 2'd1;

  localparam logic [LEN_W-1:0] PRE_LEN_RST = 13'd4096;
  localparam logic [CNT_W-1:0] CAP_LIM_RST = 17'd65536;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_PUSH,
    OP_APPEND,
    OP_DRAIN,
    OP_FINAL,
    OP_READ,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_READ,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [SMP_W-1:0] sample;
    logic                    batch_last;
    logic [RIDX_W-1:0]       read_index;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        captured_count;
    logic [LEN_W-1:0]        pre_roll_fill;
    logic signed [SMP_W-1:0] read_data;
    logic [FS_W-1:0]         wav_bytes;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [SMP_W-1:0]  sample;
    logic [RIDX_W-1:0] read_index;
  } q_entry_t;

endpackage

[rtl/ptacb_ram.sv]
`timescale 1ns / 1ps
module ptacb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ptacb_front.sv]
`timescale 1ns / 1ps
module ptacb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptacb_pkg::item_t    in_data_i,
  output logic                q_valid_o,
  output ptacb_pkg::q_entry_t q_data_o,
  input  logic                q_pop_i
);

  ptacb_pkg::q_entry_t             ent_q [ptacb_pkg::QDEPTH];
  ptacb_pkg::q_entry_t             entry;
  logic [ptacb_pkg::QPTR_W-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [ptacb_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                            push;
  logic                            pop;

  function automatic ptacb_pkg::op_e decode(input logic [ptacb_pkg::CMD_W-1:0] cmd);
    ptacb_pkg::op_e op;
    unique case (cmd)
      ptacb_pkg::CMD_CLEAR:  op = ptacb_pkg::OP_CLEAR;
      ptacb_pkg::CMD_PUSH:   op = ptacb_pkg::OP_PUSH;
      ptacb_pkg::CMD_APPEND: op = ptacb_pkg::OP_APPEND;
      ptacb_pkg::CMD_DRAIN:  op = ptacb_pkg::OP_DRAIN;
      ptacb_pkg::CMD_FINAL:  op = ptacb_pkg::OP_FINAL;
      ptacb_pkg::CMD_READ:   op = ptacb_pkg::OP_READ;
      default:               op = ptacb_pkg::OP_BAD;
    endcase
    return op;
  endfunction

  assign in_stall_o = (cnt_q == ptacb_pkg::QCNT_W'(ptacb_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_data_o   = ent_q[rp_q];

  always_comb begin
    entry.op         = decode(in_data_i.cmd);
    entry.sample     = in_data_i.sample;
    entry.read_index = in_data_i.read_index;
  end

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == ptacb_pkg::QPTR_W'(ptacb_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop) begin
      rp_d = (rp_q == ptacb_pkg::QPTR_W'(ptacb_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= entry;
    end
  end

endmodule

[rtl/ptacb_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptacb_back #(
  parameter int PRE_DEPTH    = 4096,
  parameter int CAP_DEPTH    = 65536,
  parameter int HEADER_BYTES = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ptacb_pkg::q_entry_t q_data_i,
  output logic                q_pop_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  ptacb_pkg::cfg_t     cfg_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptacb_pkg::res_t     out_data_o
);

  localparam int LEN_W = ptacb_pkg::LEN_W;
  localparam int CNT_W = ptacb_pkg::CNT_W;
  localparam int FS_W  = ptacb_pkg::FS_W;
  localparam int SMP_W = ptacb_pkg::SMP_W;
  localparam int PA_W  = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
  localparam int CA_W  = (CAP_DEPTH > 1) ? $clog2(CAP_DEPTH) : 1;
  localparam int PRE_MAX_I = (PRE_DEPTH > (2 ** LEN_W) - 1) ? (2 ** LEN_W) - 1 : PRE_DEPTH;
  localparam int CAP_MAX_I = (CAP_DEPTH > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : CAP_DEPTH;
  localparam logic [LEN_W-1:0] PRE_MAX = LEN_W'(PRE_MAX_I);
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_MAX_I);

  ptacb_pkg::state_e state_q, state_d;

  logic [LEN_W-1:0]  pre_len_q, pre_len_d;
  logic [CNT_W-1:0]  cap_lim_q, cap_lim_d;
  logic [LEN_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [LEN_W-1:0]  pre_cnt_q, pre_cnt_d;
  logic [CNT_W-1:0]  cap_cnt_q, cap_cnt_d;
  logic [FS_W-1:0]   fsize_q, fsize_d;
  logic [LEN_W-1:0]  drn_rd_q, drn_rd_d;
  logic              drn_pend_q, drn_pend_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [ptacb_pkg::STAT_W-1:0] status_q, status_d;
  logic [SMP_W-1:0]  rdata_q, rdata_d;
  logic              out_valid_q, out_valid_d;
  ptacb_pkg::res_t   out_q, out_d;

  logic [LEN_W-1:0]  ring_len;
  logic [CNT_W-1:0]  cap_lim;
  logic              can_store;
  logic              slot_free;
  logic              pop;
  logic              drain_empty;
  logic              read_ok;
  logic              drn_done;
  logic [LEN_W-1:0]  ptr_eff;
  logic [LEN_W:0]    ptr_inc;
  logic [LEN_W:0]    pos_inc;
  logic [CNT_W+1:0]  fs_sum;

  logic              load;
  logic [ptacb_pkg::STAT_W-1:0] ld_status;
  logic [SMP_W-1:0]  ld_rdata;

  logic              ring_we, ring_re;
  logic [PA_W-1:0]   ring_waddr, ring_raddr;
  logic [SMP_W-1:0]  ring_wdata, ring_rdata;
  logic              cap_we, cap_re;
  logic [CA_W-1:0]   cap_waddr, cap_raddr;
  logic [SMP_W-1:0]  cap_wdata, cap_rdata;

  ptacb_ram #(.WIDTH(SMP_W), .DEPTH(PRE_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  ptacb_ram #(.WIDTH(SMP_W), .DEPTH(CAP_DEPTH)) u_cap (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (cap_waddr),
    .wdata_i (cap_wdata),
    .re_i    (cap_re),
    .raddr_i (cap_raddr),
    .rdata_o (cap_rdata)
  );

  // zero ring length acts as one, oversize values clamp to the array depth
  assign ring_len = (pre_len_q == '0) ? LEN_W'(1) :
                    ((pre_len_q > PRE_MAX) ? PRE_MAX : pre_len_q);
  assign cap_lim   = (cap_lim_q > CAP_MAX) ? CAP_MAX : cap_lim_q;
  assign can_store = (cap_cnt_q < cap_lim);

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign pop         = (state_q == ptacb_pkg::ST_IDLE) && q_valid_i && slot_free;
  assign q_pop_o     = pop;
  assign cfg_ready_o = 1'b1;

  assign drain_empty = (pre_cnt_q == '0);
  assign read_ok     = ({1'b0, q_data_i.read_index} < cap_cnt_q);
  assign drn_done    = (drn_rd_q == pre_cnt_q) && !drn_pend_q;

  assign ptr_eff = (wr_ptr_q >= ring_len) ? '0 : wr_ptr_q;
  assign ptr_inc = {1'b0, ptr_eff} + 1'b1;
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign fs_sum  = (CNT_W + 2)'(HEADER_BYTES) + {1'b0, cap_cnt_q, 1'b0};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptacb_pkg::ST_IDLE: begin
        if (pop) begin
          if (q_data_i.op == ptacb_pkg::OP_DRAIN && !drain_empty) begin
            state_d = ptacb_pkg::ST_DRAIN;
          end else if (q_data_i.op == ptacb_pkg::OP_READ && read_ok) begin
            state_d = ptacb_pkg::ST_READ;
          end
        end
      end
      ptacb_pkg::ST_DRAIN: begin
        if (drn_done) begin
          state_d = ptacb_pkg::ST_FIN;
        end
      end
      ptacb_pkg::ST_READ: begin
        state_d = ptacb_pkg::ST_FIN;
      end
      ptacb_pkg::ST_FIN: begin
        if (slot_free) begin
          state_d = ptacb_pkg::ST_IDLE;
        end
      end
      default: state_d = ptacb_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pre_len_d  = pre_len_q;
    cap_lim_d  = cap_lim_q;
    wr_ptr_d   = wr_ptr_q;
    pre_cnt_d  = pre_cnt_q;
    cap_cnt_d  = cap_cnt_q;
    fsize_d    = fsize_q;
    drn_rd_d   = drn_rd_q;
    drn_pend_d = 1'b0;
    pos_d      = pos_q;
    status_d   = status_q;
    rdata_d    = rdata_q;
    load       = 1'b0;
    ld_status  = ptacb_pkg::STAT_OK;
    ld_rdata   = '0;
    ring_we    = 1'b0;
    ring_waddr = PA_W'(ptr_eff);
    ring_wdata = q_data_i.sample;
    ring_re    = 1'b0;
    ring_raddr = PA_W'(pos_q);
    cap_we     = 1'b0;
    cap_waddr  = CA_W'(cap_cnt_q);
    cap_wdata  = q_data_i.sample;
    cap_re     = 1'b0;
    cap_raddr  = CA_W'(q_data_i.read_index);

    unique case (state_q)
      ptacb_pkg::ST_IDLE: begin
        if (pop) begin
          case (q_data_i.op)
            ptacb_pkg::OP_CLEAR: begin
              cap_cnt_d = '0;
              fsize_d   = '0;
              pre_cnt_d = '0;
              wr_ptr_d  = '0;
              load      = 1'b1;
            end
            ptacb_pkg::OP_PUSH: begin
              ring_we  = 1'b1;
              wr_ptr_d = (ptr_inc == {1'b0, ring_len}) ? '0 : ptr_inc[LEN_W-1:0];
              if (pre_cnt_q < ring_len) begin
                pre_cnt_d = pre_cnt_q + 1'b1;
              end
              load = 1'b1;
            end
            ptacb_pkg::OP_APPEND: begin
              if (can_store) begin
                cap_we    = 1'b1;
                cap_cnt_d = cap_cnt_q + 1'b1;
              end else begin
                ld_status = ptacb_pkg::STAT_DROP;
              end
              load = 1'b1;
            end
            ptacb_pkg::OP_DRAIN: begin
              if (drain_empty) begin
                ld_status = ptacb_pkg::STAT_NONE;
                load      = 1'b1;
              end else begin
                // full ring starts at the oldest entry, a partial one at zero
                pos_d    = (pre_cnt_q < ring_len) ? '0 : wr_ptr_q;
                drn_rd_d = '0;
                status_d = ptacb_pkg::STAT_OK;
                rdata_d  = '0;
              end
            end
            ptacb_pkg::OP_FINAL: begin
              if (cap_cnt_q == '0) begin
                fsize_d   = '0;
                ld_status = ptacb_pkg::STAT_NONE;
              end else begin
                fsize_d = fs_sum[FS_W-1:0];
              end
              load = 1'b1;
            end
            ptacb_pkg::OP_READ: begin
              if (read_ok) begin
                cap_re   = 1'b1;
                status_d = ptacb_pkg::STAT_OK;
              end else begin
                ld_status = ptacb_pkg::STAT_NONE;
                load      = 1'b1;
              end
            end
            default: begin
              ld_status = ptacb_pkg::STAT_NONE;
              load      = 1'b1;
            end
          endcase
        end
      end
      ptacb_pkg::ST_DRAIN: begin
        // read stage
        if (drn_rd_q != pre_cnt_q) begin
          ring_re    = 1'b1;
          drn_pend_d = 1'b1;
          drn_rd_d   = drn_rd_q + 1'b1;
          pos_d      = (pos_inc == {1'b0, ring_len}) ? '0 : pos_inc[LEN_W-1:0];
        end
        // store stage, writes the entry read in the cycle before
        if (drn_pend_q) begin
          cap_wdata = ring_rdata;
          if (can_store) begin
            cap_we    = 1'b1;
            cap_cnt_d = cap_cnt_q + 1'b1;
          end else begin
            status_d = ptacb_pkg::STAT_DROP;
          end
        end
      end
      ptacb_pkg::ST_READ: begin
        rdata_d = cap_rdata;
      end
      ptacb_pkg::ST_FIN: begin
        if (slot_free) begin
          ld_status = status_q;
          ld_rdata  = rdata_q;
          load      = 1'b1;
        end
      end
      default: ;
    endcase

    // the user must send writes only while idle; the block itself does not enforce it
    if (cfg_valid_i) begin
      case (cfg_i.index)
        ptacb_pkg::CFG_PRE_ROLL_LEN: begin
          pre_len_d = cfg_i.data[LEN_W-1:0];
          pre_cnt_d = '0;
          wr_ptr_d  = '0;
        end
        ptacb_pkg::CFG_CAPTURE_LIMIT: begin
          cap_lim_d = cfg_i.data[CNT_W-1:0];
        end
        default: ;
      endcase
    end

    out_d.status         = ld_status;
    out_d.captured_count = cap_cnt_d;
    out_d.pre_roll_fill  = pre_cnt_d;
    out_d.read_data      = ld_rdata;
    out_d.wav_bytes      = fsize_d;
    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptacb_pkg::ST_IDLE;
      pre_len_q   <= ptacb_pkg::PRE_LEN_RST;
      cap_lim_q   <= ptacb_pkg::CAP_LIM_RST;
      wr_ptr_q    <= '0;
      pre_cnt_q   <= '0;
      cap_cnt_q   <= '0;
      fsize_q     <= '0;
      drn_rd_q    <= '0;
      drn_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pre_len_q   <= pre_len_d;
      cap_lim_q   <= cap_lim_d;
      wr_ptr_q    <= wr_ptr_d;
      pre_cnt_q   <= pre_cnt_d;
      cap_cnt_q   <= cap_cnt_d;
      fsize_q     <= fsize_d;
      drn_rd_q    <= drn_rd_d;
      drn_pend_q  <= drn_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PTACB_ASSERT(a_fill_in_ring, pre_cnt_q <= ring_len, "pre-roll fill exceeds ring length")
  `PTACB_ASSERT(a_ptr_in_ring, wr_ptr_q < ring_len, "ring write pointer out of range")
  `PTACB_ASSERT(a_cap_in_store, cap_cnt_q <= CAP_MAX, "capture count exceeds store depth")
  `PTACB_ASSERT_IMP(a_drain_bound, state_q == ptacb_pkg::ST_DRAIN, drn_rd_q <= pre_cnt_q, "drain overran the ring fill")
  `PTACB_ASSERT_IMP(a_load_free, load, slot_free, "result loaded over an untaken one")

endmodule

[rtl/pre_trigger_audio_capture_buffer_top.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | in_data_i   (ptacb_pkg::item_t)
// out     | output    | out_valid_o / out_stall_i  | out_data_o  (ptacb_pkg::res_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Clear, push, append, finalize and bad commands: one request per cycle while the output is not stalled.
// Read: the capture memory read is registered, then the result passes through the READ and FIN states.
// Drain: one ring entry a cycle through the ring read port, then the FIN state.
// Reset clears counts, pointers and state and restores the config defaults; memory contents stay undefined.
// A two-entry command queue takes requests while the back end is busy or stalled.
module pre_trigger_audio_capture_buffer_top #(
  parameter int PRE_DEPTH    = 4096,
  parameter int CAP_DEPTH    = 65536,
  parameter int HEADER_BYTES = 44
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ptacb_pkg::item_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ptacb_pkg::res_t                      out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ptacb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptacb_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  logic                q_valid;
  logic                q_pop;
  ptacb_pkg::q_entry_t q_data;
  ptacb_pkg::cfg_t     cfg;

  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  ptacb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  ptacb_back #(
    .PRE_DEPTH    (PRE_DEPTH),
    .CAP_DEPTH    (CAP_DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
